// File: src/canonical_huffman_codec_defines.svh
// Assertion macros used by the checker file of the codec.
`ifndef CANONICAL_HUFFMAN_CODEC_DEFINES_SVH
`define CANONICAL_HUFFMAN_CODEC_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define CHC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A property in which an antecedent implies a consequent in the same cycle.
`define CHC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: src/chc_pkg.sv
`timescale 1ns / 1ps
package chc_pkg;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_BUILD  = 2'd1,
    OP_ENCODE = 2'd2,
    OP_DECODE = 2'd3
  } op_e;

  // One queued command.
  typedef struct packed {
    op_e        op;
    logic [7:0] sym;
    logic [4:0] len;
    logic       bit_v;
  } cmd_t;

  // One result transaction.
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [7:0]  symbol;
    logic [15:0] code;
    logic [4:0]  code_len;
    logic        last;
  } res_t;

  localparam logic [1:0] KIND_BUILD  = 2'd0;
  localparam logic [1:0] KIND_ENCODE = 2'd1;
  localparam logic [1:0] KIND_DECODE = 2'd2;

  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_EMPTY     = 3'd1;
  localparam logic [2:0] STS_OVERSUB   = 3'd2;
  localparam logic [2:0] STS_TOO_LONG  = 3'd3;
  localparam logic [2:0] STS_DEAD      = 3'd4;
  localparam logic [2:0] STS_NOT_BUILT = 3'd5;

endpackage

// File: src/chc_front.sv
`timescale 1ns / 1ps
module chc_front import chc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] mode_i,
  input  logic [7:0] symbol_i,
  input  logic [4:0] code_length_i,
  input  logic       bit_req_i,
  input  logic       hold_i,
  input  logic       pop_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o
);

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  cmd_t       cmd_in;

  // The command is typed here so the back end only dispatches on the op.
  always_comb begin
    cmd_in.op    = op_e'(mode_i);
    cmd_in.sym   = symbol_i;
    cmd_in.len   = code_length_i;
    cmd_in.bit_v = bit_req_i;
  end

  assign busy        = (count_q == 2'd2) || hold_i;
  assign push        = start && !busy;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// File: src/chc_back.sv
`timescale 1ns / 1ps
module chc_back import chc_pkg::*; #(
  parameter int ALPHABET_SIZE = 256,
  parameter int MAX_CODE_LEN  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        pop_o,
  output logic        clearing_o,
  output logic        idle_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  output logic        res_valid_o,
  output res_t        res_o
);

  localparam int SW   = $clog2(ALPHABET_SIZE);
  localparam int NW   = $clog2(ALPHABET_SIZE + 1);
  localparam int NLEN = MAX_CODE_LEN + 1;
  localparam int LW   = $clog2(NLEN);
  localparam int PW   = MAX_CODE_LEN;
  localparam int CW   = MAX_CODE_LEN + 1;
  localparam int DW   = CW + NW;
  localparam int RW   = MAX_CODE_LEN + NW + 2;
  localparam logic [SW-1:0] LAST_SYM = SW'(ALPHABET_SIZE - 1);
  localparam logic [LW-1:0] MAX_LEN  = LW'(MAX_CODE_LEN);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_COUNT  = 3'd2;
  localparam logic [2:0] S_KRAFT  = 3'd3;
  localparam logic [2:0] S_ASSIGN = 3'd4;
  localparam logic [2:0] S_HIGH   = 3'd5;
  localparam logic [2:0] S_ENC    = 3'd6;
  localparam logic [2:0] S_DEC    = 3'd7;

  // Memories.
  logic [4:0]    len_mem  [ALPHABET_SIZE];
  logic [PW-1:0] code_mem [ALPHABET_SIZE];
  logic [SW-1:0] sort_mem [ALPHABET_SIZE];
  logic [4:0]    len_rd_q;
  logic [PW-1:0] code_rd_q;
  logic [SW-1:0] sort_rd_q;
  logic          len_we, code_we, sort_we;
  logic [SW-1:0] len_waddr, len_raddr, sort_waddr, sort_raddr;
  logic [4:0]    len_wdata;

  // Per-length tables.
  logic [NW-1:0] cnt_q  [NLEN];
  logic [NW-1:0] cnt_d  [NLEN];
  logic [CW-1:0] fc_q   [NLEN];
  logic [CW-1:0] fc_d   [NLEN];
  logic [NW-1:0] ib_q   [NLEN];
  logic [NW-1:0] ib_d   [NLEN];
  logic [NW-1:0] fill_q [NLEN];
  logic [NW-1:0] fill_d [NLEN];

  logic [2:0]        state_q, state_d;
  logic [SW-1:0]     scan_q, scan_d;
  logic              iss_done_q, iss_done_d;
  logic              pv_q, pv_d;
  logic              plast_q, plast_d;
  logic [SW-1:0]     psym_q, psym_d;
  logic              used_q, used_d;
  logic              toolong_q, toolong_d;
  logic [LW-1:0]     k_q, k_d;
  logic signed [RW-1:0] room_q, room_d;
  logic [CW-1:0]     code_q, code_d;
  logic [NW-1:0]     prev_q, prev_d;
  logic [NW-1:0]     ibacc_q, ibacc_d;
  logic [LW-1:0]     longest_q, longest_d;
  logic [PW-1:0]     highest_q, highest_d;
  logic              valid_q, valid_d;
  logic [PW-1:0]     prefix_q, prefix_d;
  logic [LW-1:0]     plen_q, plen_d;
  logic [15:0]       total_q, total_d;
  logic [15:0]       dcount_q, dcount_d;
  logic              symok_q, symok_d;
  logic              last_q, last_d;
  logic              res_v_q, res_v_d;
  res_t              res_q, res_d;

  logic [LW-1:0]     len_idx;
  logic [LW:0]       nlen;
  logic [PW-1:0]     npref;
  logic              dead, match, pos_ok, sym_in;
  logic [DW-1:0]     diff, pos_full;
  logic [15:0]       total_n;
  logic [LW-1:0]     pl;
  logic signed [RW-1:0] room_n;
  logic [CW-1:0]     code_n;
  logic [DW-1:0]     asg_code;
  logic [NW-1:0]     asg_pos;

  assign clearing_o = (state_q == S_CLEAR);
  assign idle_o     = (state_q == S_IDLE);
  assign pop_o      = (state_q == S_IDLE) && cmd_valid_i;
  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

  assign sym_in = (int'(cmd_i.sym) < ALPHABET_SIZE);
  assign pl     = LW'(len_rd_q);

  // One index serves every per-length table; its source follows the state.
  always_comb begin
    unique case (state_q)
      S_COUNT, S_ASSIGN: len_idx = pl;
      S_KRAFT:           len_idx = k_q;
      S_HIGH:            len_idx = longest_q;
      default:           len_idx = LW'(nlen);
    endcase
  end

  // Decode step on the current prefix.
  always_comb begin
    nlen     = {1'b0, plen_q} + 1'b1;
    npref    = PW'({prefix_q, cmd_i.bit_v});
    dead     = (nlen > {1'b0, longest_q}) ||
               (npref > PW'(highest_q >> (longest_q - LW'(nlen))));
    diff     = DW'(npref) - DW'(fc_q[len_idx]);
    match    = (DW'(npref) >= DW'(fc_q[len_idx])) && (diff < DW'(cnt_q[len_idx]));
    pos_full = DW'(ib_q[len_idx]) + diff;
    pos_ok   = (pos_full < DW'(ALPHABET_SIZE));
    total_n  = total_q + 16'd1;
  end

  assign room_n   = (room_q <<< 1) - $signed(RW'(cnt_q[len_idx]));
  assign code_n   = CW'((DW'(code_q) + DW'(prev_q)) << 1);
  assign asg_code = DW'(fc_q[len_idx]) + DW'(fill_q[len_idx]);
  assign asg_pos  = ib_q[len_idx] + fill_q[len_idx];
  assign sort_raddr = SW'(pos_full);

  always_comb begin
    state_d    = state_q;
    scan_d     = scan_q;
    iss_done_d = iss_done_q;
    pv_d       = 1'b0;
    plast_d    = plast_q;
    psym_d     = psym_q;
    used_d     = used_q;
    toolong_d  = toolong_q;
    k_d        = k_q;
    room_d     = room_q;
    code_d     = code_q;
    prev_d     = prev_q;
    ibacc_d    = ibacc_q;
    longest_d  = longest_q;
    highest_d  = highest_q;
    valid_d    = valid_q;
    prefix_d   = prefix_q;
    plen_d     = plen_q;
    total_d    = total_q;
    dcount_d   = dcount_q;
    symok_d    = symok_q;
    last_d     = last_q;
    cnt_d      = cnt_q;
    fc_d       = fc_q;
    ib_d       = ib_q;
    fill_d     = fill_q;
    res_v_d    = 1'b0;
    res_d      = '0;
    len_we     = 1'b0;
    len_waddr  = SW'(cmd_i.sym);
    len_wdata  = cmd_i.len;
    len_raddr  = SW'(cmd_i.sym);
    code_we    = 1'b0;
    sort_we    = 1'b0;
    sort_waddr = SW'(asg_pos);

    // Address issue for the two table scans; data returns from the registered read in the next cycle.
    if ((state_q == S_COUNT || state_q == S_ASSIGN) && !iss_done_q) begin
      len_raddr = scan_q;
      pv_d      = 1'b1;
      psym_d    = scan_q;
      plast_d   = (scan_q == LAST_SYM);
      scan_d    = scan_q + 1'b1;
      if (scan_q == LAST_SYM) begin
        iss_done_d = 1'b1;
      end
    end

    if (cfg_we_i) begin
      dcount_d = cfg_data_i;
      prefix_d = '0;
      plen_d   = '0;
      total_d  = '0;
    end

    unique case (state_q)
      S_CLEAR: begin
        len_we    = 1'b1;
        len_waddr = scan_q;
        len_wdata = 5'd0;
        scan_d    = scan_q + 1'b1;
        if (scan_q == LAST_SYM) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            OP_LOAD: begin
              if (sym_in) begin
                len_we  = 1'b1;
                valid_d = 1'b0;
              end
            end
            OP_BUILD: begin
              valid_d    = 1'b0;
              prefix_d   = '0;
              plen_d     = '0;
              total_d    = '0;
              used_d     = 1'b0;
              toolong_d  = 1'b0;
              scan_d     = '0;
              iss_done_d = 1'b0;
              for (int i = 0; i < NLEN; i++) begin
                cnt_d[i] = '0;
              end
              state_d = S_COUNT;
            end
            OP_ENCODE: begin
              if (!valid_q) begin
                res_v_d       = 1'b1;
                res_d.kind    = KIND_ENCODE;
                res_d.status  = STS_NOT_BUILT;
              end else begin
                symok_d = sym_in;
                state_d = S_ENC;
              end
            end
            default: begin
              if (!valid_q) begin
                res_v_d      = 1'b1;
                res_d.kind   = KIND_DECODE;
                res_d.status = STS_NOT_BUILT;
              end else if (!(dcount_q != 16'd0 && total_q >= dcount_q)) begin
                if (dead) begin
                  res_v_d      = 1'b1;
                  res_d.kind   = KIND_DECODE;
                  res_d.status = STS_DEAD;
                  prefix_d     = '0;
                  plen_d       = '0;
                end else if (match) begin
                  prefix_d = '0;
                  plen_d   = '0;
                  total_d  = total_n;
                  last_d   = (dcount_q != 16'd0) && (total_n == dcount_q);
                  if (pos_ok) begin
                    state_d = S_DEC;
                  end else begin
                    res_v_d      = 1'b1;
                    res_d.kind   = KIND_DECODE;
                    res_d.status = STS_OK;
                    res_d.last   = (dcount_q != 16'd0) && (total_n == dcount_q);
                  end
                end else begin
                  prefix_d = npref;
                  plen_d   = LW'(nlen);
                end
              end
            end
          endcase
        end
      end

      S_COUNT: begin
        if (pv_q) begin
          if (len_rd_q != 5'd0) begin
            used_d = 1'b1;
          end
          if (int'(len_rd_q) > MAX_CODE_LEN) begin
            toolong_d = 1'b1;
          end else if (len_rd_q != 5'd0) begin
            cnt_d[len_idx] = cnt_q[len_idx] + 1'b1;
          end
          if (plast_q) begin
            if (!used_d) begin
              res_v_d      = 1'b1;
              res_d.kind   = KIND_BUILD;
              res_d.status = STS_EMPTY;
              state_d      = S_IDLE;
            end else if (toolong_d) begin
              res_v_d      = 1'b1;
              res_d.kind   = KIND_BUILD;
              res_d.status = STS_TOO_LONG;
              state_d      = S_IDLE;
            end else begin
              k_d       = LW'(1);
              room_d    = RW'(1);
              code_d    = '0;
              prev_d    = '0;
              ibacc_d   = '0;
              longest_d = '0;
              fc_d[0]   = '0;
              ib_d[0]   = '0;
              state_d   = S_KRAFT;
            end
          end
        end
      end

      S_KRAFT: begin
        room_d         = room_n;
        code_d         = code_n;
        fc_d[len_idx]  = code_n;
        ib_d[len_idx]  = ibacc_q + prev_q;
        ibacc_d        = ibacc_q + prev_q;
        fill_d[len_idx] = '0;
        prev_d         = cnt_q[len_idx];
        if (cnt_q[len_idx] != '0) begin
          longest_d = k_q;
        end
        k_d = k_q + 1'b1;
        if (room_n < 0) begin
          res_v_d      = 1'b1;
          res_d.kind   = KIND_BUILD;
          res_d.status = STS_OVERSUB;
          state_d      = S_IDLE;
        end else if (k_q == MAX_LEN) begin
          scan_d     = '0;
          iss_done_d = 1'b0;
          state_d    = S_ASSIGN;
        end
      end

      S_ASSIGN: begin
        if (pv_q) begin
          if (len_rd_q != 5'd0) begin
            code_we         = 1'b1;
            sort_we         = 1'b1;
            fill_d[len_idx] = fill_q[len_idx] + 1'b1;
          end
          if (plast_q) begin
            state_d = S_HIGH;
          end
        end
      end

      S_HIGH: begin
        highest_d    = PW'(DW'(fc_q[len_idx]) + DW'(cnt_q[len_idx]) - DW'(1));
        valid_d      = 1'b1;
        res_v_d      = 1'b1;
        res_d.kind   = KIND_BUILD;
        res_d.status = STS_OK;
        state_d      = S_IDLE;
      end

      S_ENC: begin
        res_v_d      = 1'b1;
        res_d.kind   = KIND_ENCODE;
        res_d.status = STS_OK;
        if (symok_q && len_rd_q != 5'd0) begin
          res_d.code     = 16'(code_rd_q);
          res_d.code_len = len_rd_q;
        end
        state_d = S_IDLE;
      end

      default: begin
        res_v_d      = 1'b1;
        res_d.kind   = KIND_DECODE;
        res_d.status = STS_OK;
        res_d.symbol = 8'(sort_rd_q);
        res_d.last   = last_q;
        state_d      = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      scan_q     <= '0;
      iss_done_q <= 1'b0;
      pv_q       <= 1'b0;
      plast_q    <= 1'b0;
      used_q     <= 1'b0;
      toolong_q  <= 1'b0;
      k_q        <= '0;
      room_q     <= '0;
      code_q     <= '0;
      prev_q     <= '0;
      ibacc_q    <= '0;
      longest_q  <= '0;
      highest_q  <= '0;
      valid_q    <= 1'b0;
      prefix_q   <= '0;
      plen_q     <= '0;
      total_q    <= '0;
      dcount_q   <= '0;
      res_v_q    <= 1'b0;
      for (int i = 0; i < NLEN; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q    <= state_d;
      scan_q     <= scan_d;
      iss_done_q <= iss_done_d;
      pv_q       <= pv_d;
      plast_q    <= plast_d;
      used_q     <= used_d;
      toolong_q  <= toolong_d;
      k_q        <= k_d;
      room_q     <= room_d;
      code_q     <= code_d;
      prev_q     <= prev_d;
      ibacc_q    <= ibacc_d;
      longest_q  <= longest_d;
      highest_q  <= highest_d;
      valid_q    <= valid_d;
      prefix_q   <= prefix_d;
      plen_q     <= plen_d;
      total_q    <= total_d;
      dcount_q   <= dcount_d;
      res_v_q    <= res_v_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    psym_q  <= psym_d;
    symok_q <= symok_d;
    last_q  <= last_d;
    res_q   <= res_d;
    fc_q    <= fc_d;
    ib_q    <= ib_d;
    fill_q  <= fill_d;
  end

  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    len_rd_q <= len_mem[len_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (code_we) begin
      code_mem[psym_q] <= PW'(asg_code);
    end
    code_rd_q <= code_mem[SW'(cmd_i.sym)];
  end

  always_ff @(posedge clk_i) begin
    if (sort_we) begin
      sort_mem[sort_waddr] <= psym_q;
    end
    sort_rd_q <= sort_mem[sort_raddr];
  end

endmodule

// File: src/canonical_huffman_codec.sv
`timescale 1ns / 1ps
// Commands wait in a two-entry command queue; the back end pops the next one only when idle.
// A load, or a decode bit that completes no symbol, is handled in the idle state; an encode
// passes through S_ENC and a completed symbol that lies in the table through S_DEC, since
// every table is read through a register. A build counts lengths, walks the per-length
// Kraft and first-code tables, assigns codes in a second scan and finishes in S_HIGH.
// Reset is asynchronous and active low; afterward a clearing pass zeroes the length
// table while busy stays high. Results are single-cycle strobes the receiver cannot stall.
module canonical_huffman_codec import chc_pkg::*; #(
  parameter int ALPHABET_SIZE = 256,
  parameter int MAX_CODE_LEN  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  symbol_i,
  input  logic [4:0]  code_length_i,
  input  logic        bit_req_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [1:0]  kind_o,
  output logic [2:0]  status_o,
  output logic [7:0]  symbol_out_o,
  output logic [15:0] code_bits_o,
  output logic [4:0]  code_len_out_o,
  output logic        last_symbol_o
);

  // The front end types each transaction and queues it; the back end owns all
  // tables and walks them for builds, so a long build never blocks intake of
  // the next commands until the queue fills.
  logic cmd_valid;
  logic pop;
  logic clearing;
  logic back_idle;
  cmd_t cmd;
  res_t res;

  chc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .symbol_i     (symbol_i),
    .code_length_i(code_length_i),
    .bit_req_i    (bit_req_i),
    .hold_i       (clearing),
    .pop_i        (pop),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd)
  );

  chc_back #(
    .ALPHABET_SIZE(ALPHABET_SIZE),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .pop_o       (pop),
    .clearing_o  (clearing),
    .idle_o      (back_idle),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (result_valid_o),
    .res_o       (res)
  );

  // The decode count is taken only when nothing is queued or in flight, since
  // writing it restarts the decoder.
  assign cfg_ready_o = back_idle && !cmd_valid;

  assign kind_o         = res.kind;
  assign status_o       = res.status;
  assign symbol_out_o   = res.symbol;
  assign code_bits_o    = res.code;
  assign code_len_out_o = res.code_len;
  assign last_symbol_o  = res.last;

endmodule

// File: src/chc_checker.sv
`timescale 1ns / 1ps
`include "canonical_huffman_codec_defines.svh"
module chc_checker import chc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic        result_valid_o,
  input logic [1:0]  kind_o,
  input logic [2:0]  status_o,
  input logic [15:0] code_bits_o,
  input logic [4:0]  code_len_out_o,
  input logic        last_symbol_o
);

  `CHC_ASSERT_IMPL(a_cfg_only_idle, cfg_ready_o, !busy, "config ready while busy")
  `CHC_ASSERT_IMPL(a_last_is_symbol, result_valid_o && last_symbol_o,
                   kind_o == KIND_DECODE && status_o == STS_OK, "last flag on a non-symbol result")
  `CHC_ASSERT_IMPL(a_enc_fail_zero, result_valid_o && kind_o == KIND_ENCODE && status_o != STS_OK,
                   code_bits_o == 16'd0 && code_len_out_o == 5'd0, "failed encode has a code")
  `CHC_ASSERT(a_kind_legal, !result_valid_o || kind_o <= KIND_DECODE, "illegal result kind")

endmodule

bind canonical_huffman_codec chc_checker u_chc_checker (.*);
